@@ rtl/rcfd_pkg.sv @@
// Shared types and constants for the remote-control frame decoder and key tracker.
package rcfd_pkg;

   // Number of tracked buttons and keys; the first two are the mouse buttons.
   localparam int KEY_COUNT   = 18;
   localparam int MOUSE_KEYS  = 2;

   // Channel widths.
   localparam int REQ_TDATA_W = 144;
   localparam int RSP_TDATA_W = 184;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Field widths of one result.
   localparam int STICK_W     = 11;
   localparam int MOUSE_W     = 16;
   localparam int THRESH_W    = 10;
   localparam int LIMIT_W     = 16;
   localparam int KEY_STATE_W = 3;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_MOUSE_LONG = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LONG   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WHEEL_THR  = 2'd2;

   // Configuration reset values.
   localparam logic [LIMIT_W-1:0]  MOUSE_LONG_RESET = 16'd50;
   localparam logic [LIMIT_W-1:0]  KEY_LONG_RESET   = 16'd50;
   localparam logic [THRESH_W-1:0] WHEEL_THR_RESET  = 10'd500;

   // Item kinds carried in tuser.
   localparam logic ACTION_FRAME = 1'b0;
   localparam logic ACTION_TICK  = 1'b1;

   // Raw lever positions as sent in the frame.
   localparam logic [1:0] LEVER_POS_NONE = 2'd0;
   localparam logic [1:0] LEVER_POS_UP   = 2'd1;
   localparam logic [1:0] LEVER_POS_DOWN = 2'd2;
   localparam logic [1:0] LEVER_POS_MID  = 2'd3;

   // Per-key press state.
   typedef enum logic [KEY_STATE_W-1:0] {
      KEY_RELAX = 3'd0,
      KEY_DOWN  = 3'd1,
      KEY_SHORT = 3'd2,
      KEY_LONG  = 3'd3,
      KEY_UP    = 3'd4
   } key_state_type;

   // Lever and thumbwheel events.
   typedef enum logic [1:0] {
      EV_KEEP = 2'd0,
      EV_UP   = 2'd1,
      EV_MID  = 2'd2,
      EV_DOWN = 2'd3
   } lever_event_type;

endpackage

@@ rtl/rc_frame_decode_key_tracker.sv @@
// Top level: frame decoder with lever, thumbwheel and per-key press tracking.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------------
//  req     | in        | req_tvalid / req_tready    | tdata: 18 frame bytes, tuser: action
//  rsp     | out       | rsp_tvalid / rsp_tready    | tdata: decoded fields and key states
//  csr     | in        | csr_valid / csr_ready      | csr_index, csr_data (always ready)
//
// One item is accepted per cycle unless both registers are full and the result stalls.
// Each item waits in the input register, then is decoded and stepped through all key machines
// combinationally into the result register, from which its result is shown. The synchronous
// reset clears the key machines, lever and wheel history and decoded fields, and resets the
// configuration. A stalled result holds; the input register still takes one more item.
module rc_frame_decode_key_tracker
   import rcfd_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   // Input items.
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // [63:0] frame_low, [127:64] frame_mid, [143:128] frame_high
   input  logic [REQ_TDATA_W-1:0]  req_tdata,
   // [0] action
   input  logic                    req_tuser,
   // Result items.
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // [10:0] stick_0, [21:11] stick_1, [32:22] stick_2, [43:33] stick_3,
   // [59:44] mouse_x, [75:60] mouse_y, [91:76] mouse_z, [102:92] wheel_value,
   // [108:103] lever_events, [162:109] key_states, [180:163] key_bits, [183:181] zero
   output logic [RSP_TDATA_W-1:0]  rsp_tdata,
   // Configuration writes.
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

   // Configuration registers.
   logic [LIMIT_W-1:0]      mouse_long_ff;
   logic [LIMIT_W-1:0]      key_long_ff;
   logic [THRESH_W-1:0]     wheel_thr_ff;

   // Input register.
   logic                    s1_valid_ff;
   logic                    s1_action_ff;
   logic [63:0]             s1_low_ff;
   logic [63:0]             s1_mid_ff;
   logic [15:0]             s1_high_ff;

   // Tracking state and its next values.
   key_state_type           key_state_ff [KEY_COUNT];
   key_state_type           key_state_in [KEY_COUNT];
   logic [COUNT_WIDTH-1:0]  key_count_ff [KEY_COUNT];
   logic [COUNT_WIDTH-1:0]  key_count_in [KEY_COUNT];
   logic [1:0]              lever_last_ff [2];
   logic [1:0]              lever_last_in [2];
   lever_event_type         lever_event_ff [3];
   lever_event_type         lever_event_in [3];
   logic signed [STICK_W-1:0] wheel_last_ff;
   logic signed [STICK_W-1:0] wheel_last_in;

   // Decoded fields of the last frame, kept in raw offset form.
   logic [STICK_W-1:0]      stick_raw_ff [4];
   logic [STICK_W-1:0]      stick_raw_in [4];
   logic [STICK_W-1:0]      wheel_raw_ff;
   logic [STICK_W-1:0]      wheel_raw_in;
   logic [MOUSE_W-1:0]      mouse_ff [3];
   logic [MOUSE_W-1:0]      mouse_in [3];
   logic [KEY_COUNT-1:0]    key_bits_ff;
   logic [KEY_COUNT-1:0]    key_bits_in;

   // Result register.
   logic                    rsp_valid_ff;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff;
   logic [RSP_TDATA_W-1:0]  rsp_data_in;

   // Decode helpers.
   logic                    s1_adv;
   logic                    is_frame;
   logic [1:0]              lever_pos [2];
   logic [KEY_COUNT-1:0]    frame_bits;
   logic [STICK_W-1:0]      frame_wheel;
   logic signed [STICK_W:0] wheel_new;
   logic signed [STICK_W:0] wheel_old;
   logic signed [STICK_W:0] wheel_mag;
   logic signed [STICK_W:0] wheel_thr;
   logic [KEY_COUNT*KEY_STATE_W-1:0] key_states_vec;

   // The input register moves on when the result register is empty or being drained.
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !reset && (!s1_valid_ff || s1_adv);
   assign is_frame   = (s1_action_ff == ACTION_FRAME);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Raw fields of the frame in the input register.
   assign lever_pos[0] = s1_low_ff[47:46];
   assign lever_pos[1] = s1_low_ff[45:44];
   assign frame_bits   = {s1_mid_ff[63:48], s1_mid_ff[40], s1_mid_ff[32]};
   assign frame_wheel  = s1_high_ff[STICK_W-1:0];

   // Thumbwheel dead-zone compare in 12-bit signed arithmetic.
   assign wheel_new = {{2{~frame_wheel[STICK_W-1]}}, frame_wheel[STICK_W-2:0]};
   assign wheel_old = {wheel_last_ff[STICK_W-1], wheel_last_ff};
   assign wheel_mag = wheel_old[STICK_W] ? -wheel_old : wheel_old;
   assign wheel_thr = {2'b00, wheel_thr_ff};

   // Frame decode and lever/wheel events.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         stick_raw_in[i] = stick_raw_ff[i];
      end
      for (int i = 0; i < 3; i++) begin
         mouse_in[i]       = mouse_ff[i];
         lever_event_in[i] = lever_event_ff[i];
      end
      for (int i = 0; i < 2; i++) begin
         lever_last_in[i] = lever_last_ff[i];
      end
      wheel_raw_in  = wheel_raw_ff;
      key_bits_in   = key_bits_ff;
      wheel_last_in = wheel_last_ff;

      if (s1_adv && is_frame) begin
         stick_raw_in[0] = s1_low_ff[10:0];
         stick_raw_in[1] = s1_low_ff[21:11];
         stick_raw_in[2] = s1_low_ff[32:22];
         stick_raw_in[3] = s1_low_ff[43:33];
         mouse_in[0]     = s1_low_ff[63:48];
         mouse_in[1]     = s1_mid_ff[15:0];
         mouse_in[2]     = s1_mid_ff[31:16];
         wheel_raw_in    = frame_wheel;
         key_bits_in     = frame_bits;

         // A lever moved to position zero keeps its previous event.
         for (int i = 0; i < 2; i++) begin
            if (lever_pos[i] != lever_last_ff[i]) begin
               case (lever_pos[i])
                  LEVER_POS_UP:   lever_event_in[i] = EV_UP;
                  LEVER_POS_MID:  lever_event_in[i] = EV_MID;
                  LEVER_POS_DOWN: lever_event_in[i] = EV_DOWN;
                  default:        lever_event_in[i] = lever_event_ff[i];
               endcase
               lever_last_in[i] = lever_pos[i];
            end else begin
               lever_event_in[i] = EV_KEEP;
            end
         end

         // The wheel raises an event only when it leaves the dead zone.
         if (wheel_mag < wheel_thr) begin
            if (wheel_new > wheel_thr) begin
               lever_event_in[2] = EV_UP;
            end else if (wheel_new < -wheel_thr) begin
               lever_event_in[2] = EV_DOWN;
            end else begin
               lever_event_in[2] = EV_KEEP;
            end
         end else begin
            lever_event_in[2] = EV_KEEP;
         end
         wheel_last_in = wheel_new[STICK_W-1:0];
      end
   end

   // Per-key press machines with saturating long-press counters.
   always_comb begin
      logic [LIMIT_W-1:0]     lim;
      logic [COUNT_WIDTH-1:0] cnt_inc;
      logic                   reach_long;
      logic                   pressed;
      for (int k = 0; k < KEY_COUNT; k++) begin
         lim        = (k < MOUSE_KEYS) ? mouse_long_ff : key_long_ff;
         cnt_inc    = (key_count_ff[k] == CNT_MAX) ? key_count_ff[k]
                                                   : key_count_ff[k] + 1'b1;
         reach_long = (CMP_W'(cnt_inc) >= CMP_W'(lim));
         pressed    = frame_bits[k];
         key_state_in[k] = key_state_ff[k];
         key_count_in[k] = key_count_ff[k];
         if (s1_adv && is_frame) begin
            case (key_state_ff[k])
               KEY_RELAX: begin
                  if (pressed) begin
                     key_state_in[k] = KEY_DOWN;
                     key_count_in[k] = '0;
                  end
               end
               KEY_SHORT: begin
                  if (!pressed) begin
                     key_state_in[k] = KEY_UP;
                     key_count_in[k] = '0;
                  end else if (reach_long) begin
                     key_state_in[k] = KEY_LONG;
                     key_count_in[k] = COUNT_WIDTH'(lim);
                  end else begin
                     key_count_in[k] = cnt_inc;
                  end
               end
               KEY_LONG: begin
                  if (!pressed) begin
                     key_state_in[k] = KEY_UP;
                     key_count_in[k] = '0;
                  end
               end
               default: begin
                  key_state_in[k] = key_state_ff[k];
               end
            endcase
         end else if (s1_adv) begin
            case (key_state_ff[k])
               KEY_DOWN: begin
                  key_state_in[k] = KEY_SHORT;
                  key_count_in[k] = cnt_inc;
               end
               KEY_UP: begin
                  key_state_in[k] = KEY_RELAX;
                  key_count_in[k] = '0;
               end
               KEY_SHORT: begin
                  if (reach_long) begin
                     key_state_in[k] = KEY_LONG;
                     key_count_in[k] = COUNT_WIDTH'(lim);
                  end else begin
                     key_count_in[k] = cnt_inc;
                  end
               end
               default: begin
                  key_state_in[k] = key_state_ff[k];
               end
            endcase
         end
      end
   end

   // Result packing; centred values are the raw values with the top bit flipped.
   always_comb begin
      for (int k = 0; k < KEY_COUNT; k++) begin
         key_states_vec[KEY_STATE_W*k +: KEY_STATE_W] = key_state_in[k];
      end
      rsp_data_in = {
         3'b000,
         key_bits_in,
         key_states_vec,
         lever_event_in[2], lever_event_in[1], lever_event_in[0],
         ~wheel_raw_in[STICK_W-1], wheel_raw_in[STICK_W-2:0],
         mouse_in[2], mouse_in[1], mouse_in[0],
         ~stick_raw_in[3][STICK_W-1], stick_raw_in[3][STICK_W-2:0],
         ~stick_raw_in[2][STICK_W-1], stick_raw_in[2][STICK_W-2:0],
         ~stick_raw_in[1][STICK_W-1], stick_raw_in[1][STICK_W-2:0],
         ~stick_raw_in[0][STICK_W-1], stick_raw_in[0][STICK_W-2:0]
      };
   end

   // Configuration, input register, tracking state and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mouse_long_ff <= MOUSE_LONG_RESET;
         key_long_ff   <= KEY_LONG_RESET;
         wheel_thr_ff  <= WHEEL_THR_RESET;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int k = 0; k < KEY_COUNT; k++) begin
            key_state_ff[k] <= KEY_RELAX;
            key_count_ff[k] <= '0;
         end
         for (int i = 0; i < 2; i++) begin
            lever_last_ff[i] <= LEVER_POS_NONE;
         end
         for (int i = 0; i < 3; i++) begin
            lever_event_ff[i] <= EV_KEEP;
            mouse_ff[i]       <= '0;
         end
         for (int i = 0; i < 4; i++) begin
            stick_raw_ff[i] <= '0;
         end
         wheel_last_ff <= '0;
         wheel_raw_ff  <= '0;
         key_bits_ff   <= '0;
      end else begin
         // Register writes.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MOUSE_LONG: mouse_long_ff <= csr_data;
               CSR_KEY_LONG:   key_long_ff   <= csr_data;
               CSR_WHEEL_THR:  wheel_thr_ff  <= csr_data[THRESH_W-1:0];
               default:        mouse_long_ff <= mouse_long_ff;
            endcase
         end

         // Input register occupancy.
         if (req_tvalid && req_tready) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end

         // Result register occupancy.
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         for (int k = 0; k < KEY_COUNT; k++) begin
            key_state_ff[k] <= key_state_in[k];
            key_count_ff[k] <= key_count_in[k];
         end
         for (int i = 0; i < 2; i++) begin
            lever_last_ff[i] <= lever_last_in[i];
         end
         for (int i = 0; i < 3; i++) begin
            lever_event_ff[i] <= lever_event_in[i];
            mouse_ff[i]       <= mouse_in[i];
         end
         for (int i = 0; i < 4; i++) begin
            stick_raw_ff[i] <= stick_raw_in[i];
         end
         wheel_last_ff <= wheel_last_in;
         wheel_raw_ff  <= wheel_raw_in;
         key_bits_ff   <= key_bits_in;
      end
   end

   // Payload registers without reset.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_action_ff <= req_tuser;
         s1_low_ff    <= req_tdata[63:0];
         s1_mid_ff    <= req_tdata[127:64];
         s1_high_ff   <= req_tdata[143:128];
      end
      if (s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

@@ rtl/rcfd_checker.sv @@
// Port-level checks for the frame decoder and key tracker, bound to its top level.
module rcfd_checker
   import rcfd_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // No result is shown in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // A result that appears out of an empty output follows its transfer through both registers.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result appeared without an input transfer two cycles earlier");

   // With both registers filled, input is only taken while the output drains.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && req_tvalid && req_tready) |=>
         (rsp_tready || !req_tready))
      else $error("input taken while both stages are full and stalled");

   // A stalled result holds its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed or dropped");

endmodule

bind rc_frame_decode_key_tracker rcfd_checker u_rcfd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
